// ----- rtl/assg_pkg.sv -----
// ----------------------------------------------------------------------------
// Adjacent-swap sequence generator package
// Shared widths, constants and the structs that travel along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package assg_pkg;

    // Configuration register: number of elements.
    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] N_ELEMENTS_RESET = 4'd8;
    localparam logic [CFG_W-1:0] N_ELEMENTS_MIN = 4'd2;

    // Default and largest supported element count.
    localparam int DEFAULT_MAX_N = 8;
    localparam int MAX_N_LIMIT = 12;

    // Per-level step counter holds 0 .. m-1, m up to MAX_N_LIMIT.
    localparam int STEP_W = 4;
    // Internal swap position, 0 .. MAX_N_LIMIT-2.
    localparam int POS_W = 4;
    // Width of the swap position on the output word.
    localparam int SWAP_W = 3;

    // Stream word widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    // Handed from a level to the level below it.
    typedef struct packed {
        logic active;          // the level below produces this swap
    } assg_down_t;

    // Handed from a level to the level above it.
    typedef struct packed {
        logic [POS_W-1:0] pos; // swap position seen at this level
        logic             done; // this level finished with this swap
    } assg_up_t;

    // One result word waiting for the output side.
    typedef struct packed {
        logic [SWAP_W-1:0] swap_position;
        logic              last;
    } assg_result_t;

endpackage : assg_pkg

`default_nettype wire

// ----- rtl/adjacent_swap_sequence_generator_core.sv -----
// ----------------------------------------------------------------------------
// Adjacent-swap sequence generator core
// Plain-changes swap index generator built as a chain of per-level cells.
// ----------------------------------------------------------------------------
// Every accepted input word yields exactly one result word holding the left
// index of the adjacent pair to exchange, so that n elements walk through all
// n! orders in plain-changes order with n!-1 swaps; the final swap carries
// m_tlast and the word after it starts the sequence over. Setting the restart
// bit of an input word restarts at once, and that word already gets the first
// swap. The block takes one word per clock cycle while s_tready is high and
// registers its result: each level cell decides in the same cycle whether it
// sweeps or hands the word to the level below, and the answer ripples back
// up the chain of MAX_N-2 cells before it is registered. An output register
// with one skid stage lets the input side keep moving while one result waits.
// Writing n_elements restarts the sequence; values below 2 act as 2 and
// values above MAX_N act as MAX_N. Write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module adjacent_swap_sequence_generator_core #(
    parameter int MAX_N = assg_pkg::DEFAULT_MAX_N
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    // Configuration: n_elements
    input  wire                            cfg_wr_en,
    input  wire [assg_pkg::CFG_W-1:0]      cfg_wr_data,
    // Input words
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire [assg_pkg::S_TDATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero
    // Result words
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [assg_pkg::M_TDATA_W-1:0] m_tdata,   // [2:0] swap_position, [7:3] zero
    output logic                           m_tlast    // last
);
    import assg_pkg::*;

    logic [CFG_W-1:0] n_elements_reg;
    logic [CFG_W-1:0] n_eff;
    logic             s_fire;
    logic             restart;
    logic             seq_clear;

    // Chain links: down[m] leaves cell m toward m-1, up[m] leaves cell m
    // toward m+1. up[2] is the two-element base case.
    assg_down_t down [3:MAX_N+1];
    assg_up_t   up   [2:MAX_N];
    assg_up_t   top_result;

    assg_result_t result_word;
    assg_result_t out_word;

    assign restart = s_tdata[0];

    // Configuration register. The write also clears the level cells.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_elements_reg <= N_ELEMENTS_RESET;
        end else if (cfg_wr_en) begin
            n_elements_reg <= cfg_wr_data;
        end
    end

    // Clamp the element count into the supported range.
    always_comb begin
        if (n_elements_reg < N_ELEMENTS_MIN) begin
            n_eff = N_ELEMENTS_MIN;
        end else if (n_elements_reg > CFG_W'(MAX_N)) begin
            n_eff = CFG_W'(MAX_N);
        end else begin
            n_eff = n_elements_reg;
        end
    end

    // The level n cell starts the token; nothing enters from above the chain.
    assign down[MAX_N+1].active = 1'b0;
    // The two-element level always swaps position 0 and is always done.
    assign up[2].pos  = '0;
    assign up[2].done = 1'b1;

    genvar m;
    generate
        for (m = 3; m <= MAX_N; m++) begin : g_level
            assg_level_cell #(
                .LEVEL(m)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .n_eff    (n_eff),
                .advance  (s_fire),
                .restart  (restart),
                .clear    (seq_clear),
                .down_in  (down[m+1]),
                .down_out (down[m]),
                .up_in    (up[m-1]),
                .up_out   (up[m])
            );
        end
    endgenerate

    // The answer for the whole sequence is the one seen at the top level.
    always_comb begin
        top_result = up[2];
        for (int k = 3; k <= MAX_N; k++) begin
            if (n_eff == CFG_W'(k)) begin
                top_result = up[k];
            end
        end
    end

    // After the final swap, or on a configuration write, every level returns
    // to its starting state.
    assign seq_clear = cfg_wr_en || (s_fire && top_result.done);

    assign result_word.swap_position = top_result.pos[SWAP_W-1:0];
    assign result_word.last          = top_result.done;

    assign s_fire = s_tvalid && s_tready;

    assg_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (result_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = {{(M_TDATA_W-SWAP_W){1'b0}}, out_word.swap_position};
    assign m_tlast = out_word.last;

endmodule : adjacent_swap_sequence_generator_core

`default_nettype wire

// ----- rtl/assg_level_cell.sv -----
// ----------------------------------------------------------------------------
// Adjacent-swap level cell
// Holds the sweep counter, direction and closing flag of one recursion level.
// ----------------------------------------------------------------------------
`default_nettype none

module assg_level_cell #(
    parameter int LEVEL = 3
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire [assg_pkg::CFG_W-1:0] n_eff,
    input  wire                     advance,
    input  wire                     restart,
    input  wire                     clear,
    input  wire assg_pkg::assg_down_t down_in,
    output assg_pkg::assg_down_t    down_out,
    input  wire assg_pkg::assg_up_t up_in,
    output assg_pkg::assg_up_t      up_out
);
    import assg_pkg::*;

    localparam logic [STEP_W-1:0] STEP_DELEGATE = STEP_W'(LEVEL - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(LEVEL - 2);
    localparam logic [POS_W-1:0]  POS_TOP = POS_W'(LEVEL - 2);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              desc_reg, desc_next;
    logic              final_reg, final_next;

    logic [STEP_W-1:0] eff_step;
    logic              eff_desc;
    logic              eff_final;
    logic              active;
    logic              delegate;
    logic [POS_W-1:0]  sweep_pos;

    // A restart makes this word see the level as freshly cleared.
    assign eff_step  = restart ? '0 : step_reg;
    assign eff_desc  = restart ? 1'b1 : desc_reg;
    assign eff_final = restart ? 1'b0 : final_reg;

    assign delegate  = (eff_step == STEP_DELEGATE);
    assign active    = (n_eff == CFG_W'(LEVEL)) || down_in.active;
    assign sweep_pos = eff_desc ? (POS_TOP - POS_W'(eff_step)) : POS_W'(eff_step);

    assign down_out.active = active && delegate;

    always_comb begin
        up_out.pos  = '0;
        up_out.done = 1'b0;
        if (active) begin
            if (delegate) begin
                up_out.pos = up_in.pos + POS_W'(eff_desc);
            end else begin
                up_out.pos  = sweep_pos;
                up_out.done = eff_final && (eff_step == STEP_LAST);
            end
        end
    end

    always_comb begin
        step_next  = step_reg;
        desc_next  = desc_reg;
        final_next = final_reg;
        if (clear) begin
            step_next  = '0;
            desc_next  = 1'b1;
            final_next = 1'b0;
        end else if (advance && active) begin
            if (delegate) begin
                step_next  = '0;
                desc_next  = !eff_desc;
                final_next = eff_final || up_in.done;
            end else begin
                step_next  = eff_step + 1'b1;
                desc_next  = eff_desc;
                final_next = eff_final;
            end
        end else if (advance && restart) begin
            step_next  = '0;
            desc_next  = 1'b1;
            final_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            desc_reg  <= 1'b1;
            final_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            desc_reg  <= desc_next;
            final_reg <= final_next;
        end
    end

endmodule : assg_level_cell

`default_nettype wire

// ----- rtl/assg_out_skid.sv -----
// ----------------------------------------------------------------------------
// Adjacent-swap output buffer
// Output register plus one skid stage, so the input side never waits on a
// single stalled result word.
// ----------------------------------------------------------------------------
`default_nettype none

module assg_out_skid (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire assg_pkg::assg_result_t in_word,
    output logic                     out_valid,
    input  wire                      out_ready,
    output assg_pkg::assg_result_t   out_word
);
    import assg_pkg::*;

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    assg_result_t out_word_reg, out_word_next;
    assg_result_t skid_word_reg, skid_word_next;
    logic         in_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_word_next = skid_word_reg;
            end else begin
                out_word_next = in_word;
            end
            out_valid_next  = skid_valid_reg || in_fire;
            skid_valid_next = 1'b0;
        end else if (in_fire) begin
            skid_word_next  = in_word;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

endmodule : assg_out_skid

`default_nettype wire

// ----- tb/adjacent_swap_checker.sv -----
// ----------------------------------------------------------------------------
// Adjacent-swap sequence checker
// Watches the configuration port and both stream channels of the swap
// generator. It keeps its own copy of the per-level sweep state, works out
// the expected swap for every accepted input word and compares each result
// word with the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module adjacent_swap_checker #(
    parameter int MAX_N = assg_pkg::DEFAULT_MAX_N
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_wr_en,
    input  wire [assg_pkg::CFG_W-1:0]      cfg_wr_data,
    input  wire                            s_tvalid,
    input  wire                            s_tready,
    input  wire [assg_pkg::S_TDATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero
    input  wire                            m_tvalid,
    input  wire                            m_tready,
    input  wire [assg_pkg::M_TDATA_W-1:0]  m_tdata,   // [2:0] swap_position, [7:3] zero
    input  wire                            m_tlast,   // last
    output int                             outstanding,
    output int                             failures
);
    import assg_pkg::*;

    logic [CFG_W-1:0]  n_elements;
    logic [STEP_W-1:0] sweep_step [0:MAX_N];
    logic              sweep_down [0:MAX_N];
    logic              closing    [0:MAX_N];

    assg_result_t expected_swaps [$];
    int           fail_count;

    function automatic void clear_sweeps();
        for (int m = 0; m <= MAX_N; m++) begin
            sweep_step[m] = '0;
            sweep_down[m] = 1'b1;
            closing[m]    = 1'b0;
        end
    endfunction

    // Finds the highest level that still has positions left in its sweep,
    // takes the next position there, then walks back up through the levels
    // that handed the swap down, shifting it by one under descending sweeps.
    function automatic assg_result_t next_swap(input logic restart);
        int               n;
        int               lvl;
        int               s;
        logic [POS_W-1:0] pos;
        logic             done;
        assg_result_t     r;
        if (restart) begin
            clear_sweeps();
        end
        n = int'(n_elements);
        if (n < 2) begin
            n = 2;
        end
        if (n > MAX_N) begin
            n = MAX_N;
        end
        lvl = n;
        while (lvl > 2 && int'(sweep_step[lvl]) >= lvl - 1) begin
            lvl--;
        end
        if (lvl <= 2) begin
            pos  = '0;
            done = 1'b1;
        end else begin
            s               = int'(sweep_step[lvl]);
            pos             = sweep_down[lvl] ? POS_W'(lvl - 2 - s) : POS_W'(s);
            sweep_step[lvl] = STEP_W'(s + 1);
            done            = closing[lvl] && (s + 1 == lvl - 1);
        end
        for (int j = lvl + 1; j <= n; j++) begin
            if (sweep_down[j]) begin
                pos = pos + 1'b1;
            end
            sweep_step[j] = '0;
            sweep_down[j] = ~sweep_down[j];
            if (done) begin
                closing[j] = 1'b1;
            end
            done = 1'b0;
        end
        if (done) begin
            clear_sweeps();
        end
        r.swap_position = pos[SWAP_W-1:0];
        r.last          = done;
        return r;
    endfunction

    always @(posedge aclk) begin
        assg_result_t want;
        if (!aresetn) begin
            n_elements = N_ELEMENTS_RESET;
            clear_sweeps();
            expected_swaps.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                n_elements = cfg_wr_data;
                clear_sweeps();
            end
            // Results are checked before new expectations are queued; a word
            // accepted at this edge cannot have its result at the same edge.
            if (m_tvalid && m_tready) begin
                if (expected_swaps.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result word: pos %0d last %0d",
                             $time, m_tdata[SWAP_W-1:0], m_tlast);
                end else begin
                    want = expected_swaps.pop_front();
                    if (m_tdata[SWAP_W-1:0] !== want.swap_position ||
                        m_tlast !== want.last) begin
                        fail_count++;
                        $display("%0t: swap mismatch: expected pos %0d last %0d, %s",
                                 $time, want.swap_position, want.last,
                                 $sformatf("got pos %0d last %0d",
                                           m_tdata[SWAP_W-1:0], m_tlast));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_swaps.insert(expected_swaps.size(), next_swap(s_tdata[0]));
            end
        end
        outstanding <= expected_swaps.size();
        failures    <= fail_count;
    end

endmodule : adjacent_swap_checker

`default_nettype wire

// ----- tb/tb_adjacent_swap_sequence_generator_core.sv -----
// ----------------------------------------------------------------------------
// Adjacent-swap sequence generator testbench
// Drives restart and advance words into the generator under several element
// counts, with random bursts on the input side and random stalls on the
// output side, and lets a separate checker predict and compare every swap.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_adjacent_swap_sequence_generator_core;
    import assg_pkg::*;

    localparam int MAX_N        = DEFAULT_MAX_N;
    localparam int RANDOM_WORDS = 950;
    // CYCLE_LIMIT leaves a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT  = 200000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_W-1:0]      cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [0] restart, [7:1] zero
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // [2:0] swap_position, [7:3] zero
    logic                  m_tlast;   // last

    int outstanding;
    int failures;
    int cycle_count;
    int burst_left;
    int ready_run_left;

    adjacent_swap_sequence_generator_core #(
        .MAX_N(MAX_N)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    adjacent_swap_checker #(
        .MAX_N(MAX_N)
    ) swap_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .outstanding(outstanding),
        .failures   (failures)
    );

    always #1 aclk = ~aclk;

    // The run is cut off if it hangs; a healthy run never comes close.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver alternates between ready runs and stall runs. Stalls are
    // short, ready runs are usually short too but now and then long enough
    // to let the block stream at full rate.
    always @(posedge aclk) begin
        if (ready_run_left == 0) begin
            m_tready <= ~m_tready;
            if (m_tready) begin
                ready_run_left <= $urandom_range(1, 8);
            end else if ($urandom_range(0, 9) == 0) begin
                ready_run_left <= $urandom_range(50, 150);
            end else begin
                ready_run_left <= $urandom_range(1, 30);
            end
        end else begin
            ready_run_left <= ready_run_left - 1;
        end
    end

    // Presents one word and returns at the edge where it is taken. The sender
    // works in bursts; at the start of a burst it may hold tvalid low for a gap
    // so that gaps land at every point of the sequence.
    task automatic send_word(input logic restart);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, restart};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops the sender and waits until every expected swap has come back,
    // and lets the output register settle before returning.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (2) @(posedge aclk);
    endtask

    // A new element count is only written while the block is idle.
    task automatic set_elements(input logic [CFG_W-1:0] n);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int               words_left;
        int               words;
        int               reps;
        int               restart_pct;
        int               pick;
        logic [CFG_W-1:0] n;

        aclk           = 1'b0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cycle_count    = 0;
        burst_left     = 0;
        ready_run_left = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. The reset count of eight opens with the widest
        // position, and a restart in the middle starts over at once.
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        // Two elements: every word yields position zero flagged as last.
        set_elements(4'd2);
        send_word(1'b0);
        send_word(1'b1);
        // Counts below two behave as two.
        set_elements(4'd0);
        send_word(1'b0);
        set_elements(4'd1);
        send_word(1'b0);
        // Three elements: one full sequence, the wrap after the last swap,
        // and a restart partway through the second pass.
        set_elements(4'd3);
        repeat (6) send_word(1'b0);
        send_word(1'b1);
        // Counts above the largest level behave as the largest.
        set_elements(4'd15);
        send_word(1'b0);
        send_word(1'b0);
        set_elements(4'd9);
        send_word(1'b0);
        set_elements(4'd4);
        send_word(1'b1);
        send_word(1'b0);

        // Random part. Most phases run whole sequences of a small count so
        // that every level reaches its closing sweep; the rest are partial
        // runs at large counts, out-of-range counts and restart noise.
        words_left = RANDOM_WORDS;
        while (words_left > 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                n    = CFG_W'($urandom_range(2, 5));
                reps = $urandom_range(1, 2);
                set_elements(n);
                words = 1;
                for (int k = 2; k <= int'(n); k++) begin
                    words *= k;
                end
                words       = (words - 1) * reps + $urandom_range(0, 3);
                restart_pct = 0;
            end else if (pick < 8) begin
                set_elements(CFG_W'($urandom_range(6, MAX_N)));
                words       = $urandom_range(20, 120);
                restart_pct = 3;
            end else if (pick == 8) begin
                n = ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(0, 1))
                                                : CFG_W'($urandom_range(MAX_N + 1, 15));
                set_elements(n);
                words       = $urandom_range(5, 40);
                restart_pct = 20;
            end else begin
                // Keep the current count and setting; the sender does not stop.
                words       = $urandom_range(10, 40);
                restart_pct = 50;
            end
            if (words > words_left) begin
                words = words_left;
            end
            words_left -= words;
            repeat (words) send_word($urandom_range(0, 99) < restart_pct);
        end

        drain();
        repeat (4) @(posedge aclk);
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule : tb_adjacent_swap_sequence_generator_core

`default_nettype wire
